>>> rtl/c3rb_pkg.sv
// ----------------------------------------------------------------------------
// c3rb_pkg
// Shared constants, types and helpers of the 3x3 replicate-border convolution.
// ----------------------------------------------------------------------------
`default_nettype none

package c3rb_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int PIX_BITS     = 16;
    localparam int COEF_BITS    = 16;
    localparam int CFG_BITS     = 48;
    localparam int DIM_BITS     = 11;
    localparam int CFG_IDX_BITS = 3;
    localparam int FILT_BITS    = 35;
    localparam int PROD_BITS    = PIX_BITS + COEF_BITS;
    localparam int RSUM_BITS    = PROD_BITS + 2;
    localparam int COL_BITS     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int EMIT_COUNT   = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_TOP = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_MID = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_BOT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT   = 3'd4;

    localparam logic [CFG_BITS-1:0] COEF_TOP_RST = 48'd0;
    localparam logic [CFG_BITS-1:0] COEF_MID_RST = 48'd65536;
    localparam logic [CFG_BITS-1:0] COEF_BOT_RST = 48'd0;
    localparam logic [DIM_BITS-1:0] WIDTH_RST    = 11'd1024;
    localparam logic [DIM_BITS-1:0] HEIGHT_RST   = 11'd1024;

    // result kinds of one item, in output order
    localparam int EMIT_CENTER = 0;
    localparam int EMIT_RIGHT  = 1;
    localparam int EMIT_BOTTOM = 2;
    localparam int EMIT_CORNER = 3;

    typedef logic signed [PIX_BITS-1:0] pix_t;
    typedef pix_t [2:0][2:0] win_t;
    typedef logic [EMIT_COUNT-1:0] emit_t;

    typedef struct packed {
        emit_t emit;
        win_t  win;
    } job_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
    } dims_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] top;
        logic [CFG_BITS-1:0] mid;
        logic [CFG_BITS-1:0] bot;
    } coefs_t;

    function automatic logic [DIM_BITS-1:0] clamp_dim(
        input logic [DIM_BITS-1:0] v,
        input logic [DIM_BITS-1:0] maxv
    );
        logic [DIM_BITS-1:0] res;
        if (v == '0) begin
            res = DIM_BITS'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [1:0] sel_idx(input logic [1:0] i, input logic use_b);
        logic [1:0] res;
        if (use_b) begin
            res = (i == 2'd0) ? 2'd1 : 2'd2;
        end else begin
            res = i;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/c3rb_ram.sv
// ----------------------------------------------------------------------------
// c3rb_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
`default_nettype none

module c3rb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                                         aclk,
    input  wire logic                                         wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                             wr_data,
    input  wire logic                                         rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output      logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/c3rb_front.sv
// ----------------------------------------------------------------------------
// c3rb_front
// Pixel intake: position counters, line stores, 3x3 window, result classing.
// ----------------------------------------------------------------------------
`default_nettype none

module c3rb_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire c3rb_pkg::pix_t    s_pixel_in,
    input  wire logic              s_valid,
    output      logic              s_ready,
    input  wire c3rb_pkg::dims_t   dims,
    output      logic              q_push,
    output      c3rb_pkg::job_t    q_push_data,
    input  wire logic              q_full
);

    logic [c3rb_pkg::COL_BITS-1:0] col_reg, col_next;
    logic [c3rb_pkg::ROW_BITS-1:0] row_reg, row_next;
    logic [c3rb_pkg::DIM_BITS-1:0] w, h, col_inc, row_inc;
    logic                          row_end, last_row, accept;
    logic                          r_ge1, r_ge2, c_ge1;
    c3rb_pkg::emit_t               emit;

    logic                          st1_valid_reg, st1_valid_next;
    c3rb_pkg::pix_t                st1_pix_reg;
    logic [c3rb_pkg::COL_BITS-1:0] st1_col_reg;
    logic                          st1_r_ge1_reg, st1_r_ge2_reg;
    c3rb_pkg::emit_t               st1_emit_reg;
    logic                          st1_fire;

    logic                          byp_one_reg, byp_two_reg, same_col;
    c3rb_pkg::pix_t                byp_one_pix_reg, byp_two_pix_reg;

    logic [c3rb_pkg::PIX_BITS-1:0] one_rd, two_rd;
    c3rb_pkg::pix_t                one_val, two_val, top_pix, mid_pix;
    c3rb_pkg::win_t                win_reg, win_next;

    assign w = c3rb_pkg::clamp_dim(dims.width, c3rb_pkg::DIM_BITS'(c3rb_pkg::MAX_WIDTH));
    assign h = c3rb_pkg::clamp_dim(dims.height, c3rb_pkg::DIM_BITS'(c3rb_pkg::MAX_HEIGHT));

    assign col_inc  = c3rb_pkg::DIM_BITS'(col_reg) + c3rb_pkg::DIM_BITS'(1);
    assign row_inc  = c3rb_pkg::DIM_BITS'(row_reg) + c3rb_pkg::DIM_BITS'(1);
    assign row_end  = col_inc >= w;
    assign last_row = row_inc >= h;
    assign r_ge1    = row_reg != '0;
    assign r_ge2    = row_reg > c3rb_pkg::ROW_BITS'(1);
    assign c_ge1    = col_reg != '0;

    always_comb begin
        emit = '0;
        emit[c3rb_pkg::EMIT_CENTER] = r_ge1 & c_ge1;
        emit[c3rb_pkg::EMIT_RIGHT]  = r_ge1 & row_end;
        emit[c3rb_pkg::EMIT_BOTTOM] = last_row & c_ge1;
        emit[c3rb_pkg::EMIT_CORNER] = last_row & row_end;
    end

    assign st1_fire = st1_valid_reg & ((st1_emit_reg == '0) | ~q_full);
    assign s_ready  = ~st1_valid_reg | st1_fire;
    assign accept   = s_valid & s_ready;
    assign same_col = st1_fire & (st1_col_reg == col_reg);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (row_end) begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[c3rb_pkg::ROW_BITS-1:0];
            end else begin
                col_next = col_inc[c3rb_pkg::COL_BITS-1:0];
            end
        end
        if (accept) begin
            st1_valid_next = 1'b1;
        end else if (st1_fire) begin
            st1_valid_next = 1'b0;
        end else begin
            st1_valid_next = st1_valid_reg;
        end
    end

    c3rb_ram #(
        .WIDTH (c3rb_pkg::PIX_BITS),
        .DEPTH (c3rb_pkg::MAX_WIDTH)
    ) u_line_one (
        .aclk    (aclk),
        .wr_en   (st1_fire),
        .wr_addr (st1_col_reg),
        .wr_data (st1_pix_reg),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (one_rd)
    );

    c3rb_ram #(
        .WIDTH (c3rb_pkg::PIX_BITS),
        .DEPTH (c3rb_pkg::MAX_WIDTH)
    ) u_line_two (
        .aclk    (aclk),
        .wr_en   (st1_fire & st1_r_ge1_reg),
        .wr_addr (st1_col_reg),
        .wr_data (one_val),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (two_rd)
    );

    always_comb begin
        one_val = byp_one_reg ? byp_one_pix_reg : c3rb_pkg::pix_t'(one_rd);
        two_val = byp_two_reg ? byp_two_pix_reg : c3rb_pkg::pix_t'(two_rd);
        if (st1_r_ge2_reg) begin
            top_pix = two_val;
        end else if (st1_r_ge1_reg) begin
            top_pix = one_val;
        end else begin
            top_pix = st1_pix_reg;
        end
        mid_pix = st1_r_ge1_reg ? one_val : st1_pix_reg;

        win_next = win_reg;
        if (st1_col_reg == '0) begin
            for (int k = 0; k < 3; k++) begin
                win_next[0][k] = top_pix;
                win_next[1][k] = mid_pix;
                win_next[2][k] = st1_pix_reg;
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                win_next[i][0] = win_reg[i][1];
                win_next[i][1] = win_reg[i][2];
            end
            win_next[0][2] = top_pix;
            win_next[1][2] = mid_pix;
            win_next[2][2] = st1_pix_reg;
        end
    end

    assign q_push           = st1_fire & (st1_emit_reg != '0);
    assign q_push_data.emit = st1_emit_reg;
    assign q_push_data.win  = win_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            st1_valid_reg <= st1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_pix_reg     <= s_pixel_in;
            st1_col_reg     <= col_reg;
            st1_r_ge1_reg   <= r_ge1;
            st1_r_ge2_reg   <= r_ge2;
            st1_emit_reg    <= emit;
            byp_one_reg     <= same_col;
            byp_two_reg     <= same_col & st1_r_ge1_reg;
            byp_one_pix_reg <= st1_pix_reg;
            byp_two_pix_reg <= one_val;
        end
        if (st1_fire) begin
            win_reg <= win_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/c3rb_queue.sv
// ----------------------------------------------------------------------------
// c3rb_queue
// Short FIFO of classified windows between intake and arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module c3rb_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire c3rb_pkg::job_t  push_data,
    output      logic            full,
    input  wire logic            pop,
    output      c3rb_pkg::job_t  head,
    output      logic            empty
);

    c3rb_pkg::job_t                 entry_reg [c3rb_pkg::QUEUE_DEPTH];
    logic [c3rb_pkg::QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [c3rb_pkg::QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [c3rb_pkg::QCNT_BITS-1:0] count_reg, count_next;

    assign full  = count_reg == c3rb_pkg::QCNT_BITS'(c3rb_pkg::QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == c3rb_pkg::QPTR_BITS'(c3rb_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + c3rb_pkg::QPTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == c3rb_pkg::QPTR_BITS'(c3rb_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + c3rb_pkg::QPTR_BITS'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + c3rb_pkg::QCNT_BITS'(1);
        end else if (pop && !push) begin
            count_next = count_reg - c3rb_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/c3rb_back.sv
// ----------------------------------------------------------------------------
// c3rb_back
// Result issue and multiply-accumulate pipeline: products, row sums, total.
// ----------------------------------------------------------------------------
`default_nettype none

module c3rb_back (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire c3rb_pkg::coefs_t                       coefs,
    input  wire c3rb_pkg::job_t                         q_head,
    input  wire logic                                   q_empty,
    output      logic                                   q_pop,
    output      logic signed [c3rb_pkg::FILT_BITS-1:0]  m_filtered,
    output      logic                                   m_run_last,
    output      logic                                   m_frame_last,
    output      logic                                   m_valid,
    input  wire logic                                   m_ready
);

    logic                  adv, issue, item_done, row_b, col_b;
    c3rb_pkg::emit_t       done_reg, done_next, pending, cur_oh;
    logic [c3rb_pkg::CFG_BITS-1:0] coef_row [3];

    logic signed [c3rb_pkg::PROD_BITS-1:0] prod_next [3][3];
    logic signed [c3rb_pkg::PROD_BITS-1:0] prod_reg  [3][3];
    logic signed [c3rb_pkg::RSUM_BITS-1:0] rsum_next [3];
    logic signed [c3rb_pkg::RSUM_BITS-1:0] rsum_reg  [3];
    logic signed [c3rb_pkg::FILT_BITS-1:0] total_next, m_filtered_reg;

    logic p0_valid_reg, p0_run_last_reg, p0_frame_last_reg;
    logic s1_valid_reg, s1_run_last_reg, s1_frame_last_reg;
    logic m_valid_reg, m_run_last_reg, m_frame_last_reg;

    assign adv     = ~m_valid_reg | m_ready;
    assign issue   = adv & ~q_empty;
    assign pending = q_head.emit & ~done_reg;

    always_comb begin
        cur_oh = '0;
        if (pending[c3rb_pkg::EMIT_CENTER]) begin
            cur_oh[c3rb_pkg::EMIT_CENTER] = 1'b1;
        end else if (pending[c3rb_pkg::EMIT_RIGHT]) begin
            cur_oh[c3rb_pkg::EMIT_RIGHT] = 1'b1;
        end else if (pending[c3rb_pkg::EMIT_BOTTOM]) begin
            cur_oh[c3rb_pkg::EMIT_BOTTOM] = 1'b1;
        end else begin
            cur_oh[c3rb_pkg::EMIT_CORNER] = 1'b1;
        end
    end

    assign item_done = (pending & ~cur_oh) == '0;
    assign q_pop     = issue & item_done;
    assign row_b     = cur_oh[c3rb_pkg::EMIT_BOTTOM] | cur_oh[c3rb_pkg::EMIT_CORNER];
    assign col_b     = cur_oh[c3rb_pkg::EMIT_RIGHT] | cur_oh[c3rb_pkg::EMIT_CORNER];

    always_comb begin
        done_next = done_reg;
        if (issue) begin
            done_next = item_done ? '0 : (done_reg | cur_oh);
        end
    end

    assign coef_row[0] = coefs.top;
    assign coef_row[1] = coefs.mid;
    assign coef_row[2] = coefs.bot;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[i][j] =
                    c3rb_pkg::PROD_BITS'($signed(
                        q_head.win[c3rb_pkg::sel_idx(2'(i), row_b)]
                                  [c3rb_pkg::sel_idx(2'(j), col_b)])) *
                    c3rb_pkg::PROD_BITS'($signed(
                        coef_row[i][c3rb_pkg::COEF_BITS*j +: c3rb_pkg::COEF_BITS]));
            end
        end
        for (int i = 0; i < 3; i++) begin
            rsum_next[i] = c3rb_pkg::RSUM_BITS'(prod_reg[i][0])
                         + c3rb_pkg::RSUM_BITS'(prod_reg[i][1])
                         + c3rb_pkg::RSUM_BITS'(prod_reg[i][2]);
        end
        total_next = c3rb_pkg::FILT_BITS'(rsum_reg[0])
                   + c3rb_pkg::FILT_BITS'(rsum_reg[1])
                   + c3rb_pkg::FILT_BITS'(rsum_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg     <= '0;
            p0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            done_reg <= done_next;
            if (adv) begin
                p0_valid_reg <= issue;
                s1_valid_reg <= p0_valid_reg;
                m_valid_reg  <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg          <= prod_next;
            p0_run_last_reg   <= item_done;
            p0_frame_last_reg <= cur_oh[c3rb_pkg::EMIT_CORNER];
            rsum_reg          <= rsum_next;
            s1_run_last_reg   <= p0_run_last_reg;
            s1_frame_last_reg <= p0_frame_last_reg;
            m_filtered_reg    <= total_next;
            m_run_last_reg    <= s1_run_last_reg;
            m_frame_last_reg  <= s1_frame_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_filtered   = m_filtered_reg;
    assign m_run_last   = m_run_last_reg;
    assign m_frame_last = m_frame_last_reg;

endmodule

`default_nettype wire

>>> rtl/conv3x3_replicate_border.sv
// ----------------------------------------------------------------------------
// conv3x3_replicate_border
// A pixel's results pass through the intake stage register, the queue, and the
// product, row-sum and output registers of the multiply-accumulate pipeline.
// Throughput: one pixel per cycle while the queue has room; a pixel with several
// results issues them one by one into the pipeline, a 4-entry queue absorbs bursts.
// Reset (aresetn low, synchronous) clears counters, queue and pipeline valid
// state and restores the identity kernel and a 1024 x 1024 image size.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_replicate_border (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        cfg_wr_en,
    input  wire logic [c3rb_pkg::CFG_IDX_BITS-1:0]           cfg_index,
    input  wire logic [c3rb_pkg::CFG_BITS-1:0]               cfg_data,
    input  wire logic signed [c3rb_pkg::PIX_BITS-1:0]        s_pixel_in,
    input  wire logic                                        s_valid,
    output      logic                                        s_ready,
    output      logic signed [c3rb_pkg::FILT_BITS-1:0]       m_filtered,
    output      logic                                        m_run_last,
    output      logic                                        m_frame_last,
    output      logic                                        m_valid,
    input  wire logic                                        m_ready
);

    logic [c3rb_pkg::CFG_BITS-1:0] coef_top_reg, coef_mid_reg, coef_bot_reg;
    logic [c3rb_pkg::DIM_BITS-1:0] width_reg, height_reg;

    c3rb_pkg::dims_t  dims;
    c3rb_pkg::coefs_t coefs;
    c3rb_pkg::job_t   q_push_data, q_head;
    logic             q_push, q_full, q_pop, q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_top_reg <= c3rb_pkg::COEF_TOP_RST;
            coef_mid_reg <= c3rb_pkg::COEF_MID_RST;
            coef_bot_reg <= c3rb_pkg::COEF_BOT_RST;
            width_reg    <= c3rb_pkg::WIDTH_RST;
            height_reg   <= c3rb_pkg::HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                c3rb_pkg::CFG_COEF_TOP: begin
                    coef_top_reg <= cfg_data;
                end
                c3rb_pkg::CFG_COEF_MID: begin
                    coef_mid_reg <= cfg_data;
                end
                c3rb_pkg::CFG_COEF_BOT: begin
                    coef_bot_reg <= cfg_data;
                end
                c3rb_pkg::CFG_WIDTH: begin
                    width_reg <= cfg_data[c3rb_pkg::DIM_BITS-1:0];
                end
                c3rb_pkg::CFG_HEIGHT: begin
                    height_reg <= cfg_data[c3rb_pkg::DIM_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign dims.width  = width_reg;
    assign dims.height = height_reg;
    assign coefs.top   = coef_top_reg;
    assign coefs.mid   = coef_mid_reg;
    assign coefs.bot   = coef_bot_reg;

    c3rb_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_pixel_in  (s_pixel_in),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .dims        (dims),
        .q_push      (q_push),
        .q_push_data (q_push_data),
        .q_full      (q_full)
    );

    c3rb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    c3rb_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .coefs        (coefs),
        .q_head       (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .m_filtered   (m_filtered),
        .m_run_last   (m_run_last),
        .m_frame_last (m_frame_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

    a_frame_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_last |-> m_run_last)
        else $error("frame end result not marked as last of its item");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("window pushed into a full queue");

    a_pop_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("result issued from an empty queue");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
